### rtl/core/mcpp_pkg.sv
// ----------------------------------------------------------------------------
// MQTT client packet parser package
// Shared types and codes for the byte-serial MQTT 3.1.1 packet parser.
// ----------------------------------------------------------------------------
package mcpp_pkg;

   localparam int unsigned LEN_W = 28;

   typedef enum logic [1:0] {
      PH_TYPE,
      PH_LEN,
      PH_BODY,
      PH_HALT
   } phase_type;

   localparam logic [2:0] ROLE_TYPE    = 3'd0;
   localparam logic [2:0] ROLE_LEN     = 3'd1;
   localparam logic [2:0] ROLE_FIXED   = 3'd2;
   localparam logic [2:0] ROLE_TOPIC   = 3'd3;
   localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
   localparam logic [2:0] ROLE_CODE    = 3'd5;
   localparam logic [2:0] ROLE_DROP    = 3'd6;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_QOS2      = 2'd2;

   localparam logic [3:0] PKT_CONNACK  = 4'd2;
   localparam logic [3:0] PKT_PUBLISH  = 4'd3;
   localparam logic [3:0] PKT_PUBACK   = 4'd4;
   localparam logic [3:0] PKT_PUBREC   = 4'd5;
   localparam logic [3:0] PKT_PUBREL   = 4'd6;
   localparam logic [3:0] PKT_PUBCOMP  = 4'd7;
   localparam logic [3:0] PKT_SUBACK   = 4'd9;
   localparam logic [3:0] PKT_UNSUBACK = 4'd11;
   localparam logic [3:0] PKT_PINGRESP = 4'd13;

   localparam logic [1:0] QOS_0 = 2'd0;
   localparam logic [1:0] QOS_1 = 2'd1;
   localparam logic [1:0] QOS_2 = 2'd2;
   localparam logic [1:0] QOS_3 = 2'd3;

   localparam logic [3:0] FLAGS_NONE   = 4'h0;
   localparam logic [3:0] FLAGS_PUBREL = 4'h2;

   typedef struct packed {
      logic [2:0]       byte_role;
      logic [7:0]       data_out;
      logic             packet_done;
      logic [1:0]       status;
      logic [3:0]       packet_type;
      logic [3:0]       header_flags;
      logic             session_flag;
      logic [7:0]       connack_code;
      logic [15:0]      packet_ident;
      logic [15:0]      topic_length;
      logic [LEN_W-1:0] body_count;
   } rsp_type;

endpackage

### rtl/core/mcpp_if.sv
// ----------------------------------------------------------------------------
// MQTT client packet parser channels
// Valid/ready channels for the received byte and the tagged result.
// ----------------------------------------------------------------------------
interface mcpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mcpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_role;
   logic [7:0]  data_out;
   logic        packet_done;
   logic [1:0]  status;
   logic [3:0]  packet_type;
   logic [3:0]  header_flags;
   logic        session_flag;
   logic [7:0]  connack_code;
   logic [15:0] packet_ident;
   logic [15:0] topic_length;
   logic [27:0] body_count;

   modport source (output valid, output byte_role, output data_out, output packet_done,
                   output status, output packet_type, output header_flags,
                   output session_flag, output connack_code, output packet_ident,
                   output topic_length, output body_count, input ready);
   modport sink   (input valid, input byte_role, input data_out, input packet_done,
                   input status, input packet_type, input header_flags,
                   input session_flag, input connack_code, input packet_ident,
                   input topic_length, input body_count, output ready);
endinterface

### rtl/core/mcpp_in_stage.sv
// ----------------------------------------------------------------------------
// MQTT parser input register
// Captures one request byte and holds it until the parse step consumes it.
// ----------------------------------------------------------------------------
module mcpp_in_stage (
   input  logic       clock,
   input  logic       reset,
   mcpp_req_if.sink   req_chan,
   input  logic       advance,
   output logic       valid_ff,
   output logic [7:0] byte_ff
);

   logic       valid_in;
   logic [7:0] byte_in;
   logic       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_chan.data_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

endmodule

### rtl/core/mcpp_parse.sv
// ----------------------------------------------------------------------------
// MQTT parser step
// Packet state and the per-byte decode that tags the byte and checks packets.
// ----------------------------------------------------------------------------
module mcpp_parse import mcpp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   output rsp_type    result
);

   phase_type        phase_ff, phase_in;
   logic [3:0]       type_ff, flags_ff;
   logic [LEN_W-1:0] rl_ff, pos_ff;
   logic [1:0]       idx_ff;
   logic [15:0]      tl_ff, id_ff;
   logic [7:0]       fcb_ff;

   logic [LEN_W-1:0] len_grp, rl_len, rl_fin;
   logic [1:0]       qos;
   logic [LEN_W:0]   pos_x, rl_x, tl_x, topic_end;
   logic             pos_last;
   logic [7:0]       fcb_eff;
   logic [15:0]      tl_eff, id_eff;
   logic             id_upd;
   logic [2:0]       body_role;
   logic             len_overflow, len_zero;

   logic [1:0]       fin_st;
   logic             fin_sp;
   logic [7:0]       fin_rc;
   logic [15:0]      fin_id, fin_tl;
   logic [LEN_W-1:0] fin_body;
   logic [LEN_W:0]   pub_end;

   // Length groups are disjoint, so the add never carries into a used group.
   assign len_grp      = LEN_W'(data_byte[6:0]) << (5'(idx_ff) * 5'd7);
   assign rl_len       = rl_ff + len_grp;
   assign len_overflow = data_byte[7] && (idx_ff == 2'd3);
   assign len_zero     = !data_byte[7] && (rl_len == '0);
   assign rl_fin       = (phase_ff == PH_LEN) ? rl_len : rl_ff;

   assign qos       = flags_ff[2:1];
   assign pos_x     = (LEN_W+1)'(pos_ff);
   assign rl_x      = (LEN_W+1)'(rl_ff);
   assign tl_x      = (LEN_W+1)'(tl_ff);
   assign topic_end = tl_x + (LEN_W+1)'(2);
   assign pos_last  = (pos_x + (LEN_W+1)'(1)) >= rl_x;

   assign fcb_eff = (pos_ff == '0) ? data_byte : fcb_ff;
   assign tl_eff  = (type_ff == PKT_PUBLISH && pos_ff == LEN_W'(1)) ?
                    {fcb_ff, data_byte} : tl_ff;

   always_comb begin
      if (type_ff == PKT_PUBLISH) begin
         id_upd = (qos == QOS_1) && (pos_x >= (LEN_W+1)'(2)) &&
                  (pos_x == topic_end || pos_x == topic_end + (LEN_W+1)'(1));
      end else begin
         id_upd = pos_ff < LEN_W'(2);
      end
   end
   assign id_eff = id_upd ? {id_ff[7:0], data_byte} : id_ff;

   always_comb begin
      unique case (type_ff) inside
         PKT_CONNACK, PKT_PUBACK, PKT_PUBREC, PKT_PUBREL, PKT_PUBCOMP, PKT_UNSUBACK: begin
            body_role = (pos_ff < LEN_W'(2)) ? ROLE_FIXED : ROLE_DROP;
         end
         PKT_SUBACK: begin
            body_role = (pos_ff < LEN_W'(2)) ? ROLE_FIXED : ROLE_CODE;
         end
         PKT_PUBLISH: begin
            if (qos[1]) begin
               body_role = ROLE_DROP;
            end else if (pos_ff < LEN_W'(2)) begin
               body_role = ROLE_FIXED;
            end else if (pos_x < topic_end) begin
               body_role = ROLE_TOPIC;
            end else if (qos == QOS_1 && pos_x < topic_end + (LEN_W+1)'(2)) begin
               body_role = ROLE_FIXED;
            end else begin
               body_role = ROLE_PAYLOAD;
            end
         end
         default: begin
            body_role = ROLE_DROP;
         end
      endcase
   end

   // Packet check on its last byte, using the field values this byte leaves.
   assign pub_end = (LEN_W+1)'(tl_eff) + (LEN_W+1)'(2);

   always_comb begin
      fin_st   = ST_OK;
      fin_sp   = 1'b0;
      fin_rc   = '0;
      fin_id   = '0;
      fin_tl   = '0;
      fin_body = '0;
      unique case (type_ff) inside
         PKT_CONNACK: begin
            if (rl_fin != LEN_W'(2) || flags_ff != FLAGS_NONE || fcb_eff[7:1] != '0) begin
               fin_st = ST_MALFORMED;
            end else begin
               fin_sp = fcb_eff[0];
               fin_rc = data_byte;
            end
         end
         PKT_PUBLISH: begin
            if (qos == QOS_3) begin
               fin_st = ST_MALFORMED;
            end else if (qos == QOS_2) begin
               fin_st = ST_QOS2;
            end else if (rl_fin < LEN_W'(2) || pub_end > (LEN_W+1)'(rl_fin)) begin
               fin_st = ST_MALFORMED;
            end else if (qos == QOS_1) begin
               if (pub_end + (LEN_W+1)'(2) > (LEN_W+1)'(rl_fin)) begin
                  fin_st = ST_MALFORMED;
               end else begin
                  fin_id   = id_eff;
                  fin_tl   = tl_eff;
                  fin_body = LEN_W'((LEN_W+1)'(rl_fin) - pub_end - (LEN_W+1)'(2));
               end
            end else begin
               fin_tl   = tl_eff;
               fin_body = LEN_W'((LEN_W+1)'(rl_fin) - pub_end);
            end
         end
         PKT_PUBACK, PKT_PUBREC, PKT_PUBCOMP, PKT_UNSUBACK: begin
            if (rl_fin != LEN_W'(2) || flags_ff != FLAGS_NONE) begin
               fin_st = ST_MALFORMED;
            end else begin
               fin_id = id_eff;
            end
         end
         PKT_PUBREL: begin
            if (rl_fin != LEN_W'(2) || flags_ff != FLAGS_PUBREL) begin
               fin_st = ST_MALFORMED;
            end else begin
               fin_id = id_eff;
            end
         end
         PKT_SUBACK: begin
            if (rl_fin < LEN_W'(3) || flags_ff != FLAGS_NONE) begin
               fin_st = ST_MALFORMED;
            end else begin
               fin_id   = id_eff;
               fin_body = rl_fin - LEN_W'(2);
            end
         end
         PKT_PINGRESP: begin
            if (rl_fin != '0 || flags_ff != FLAGS_NONE) begin
               fin_st = ST_MALFORMED;
            end
         end
         default: begin
            fin_st = ST_MALFORMED;
         end
      endcase
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_TYPE: begin
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            if (len_overflow) begin
               phase_in = PH_HALT;
            end else if (data_byte[7]) begin
               phase_in = PH_LEN;
            end else if (len_zero) begin
               phase_in = (fin_st == ST_OK) ? PH_TYPE : PH_HALT;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (pos_last) begin
               phase_in = (fin_st == ST_OK) ? PH_TYPE : PH_HALT;
            end
         end
         PH_HALT: begin
            phase_in = PH_HALT;
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase
   end

   // Result for the current byte.
   always_comb begin
      result          = '0;
      result.data_out = data_byte;
      unique case (phase_ff) inside
         PH_TYPE: begin
            result.byte_role    = ROLE_TYPE;
            result.packet_type  = data_byte[7:4];
            result.header_flags = data_byte[3:0];
         end
         PH_LEN, PH_BODY: begin
            result.byte_role    = (phase_ff == PH_LEN) ? ROLE_LEN : body_role;
            result.packet_type  = type_ff;
            result.header_flags = flags_ff;
            if (phase_ff == PH_LEN && len_overflow) begin
               result.packet_done = 1'b1;
               result.status      = ST_MALFORMED;
            end else if ((phase_ff == PH_LEN && len_zero) ||
                         (phase_ff == PH_BODY && pos_last)) begin
               result.packet_done = 1'b1;
               result.status      = fin_st;
               if (fin_st == ST_OK) begin
                  result.session_flag = fin_sp;
                  result.connack_code = fin_rc;
                  result.packet_ident = fin_id;
                  result.topic_length = fin_tl;
                  result.body_count   = fin_body;
               end
            end
         end
         PH_HALT: begin
            result.byte_role = ROLE_DROP;
         end
         default: begin
            result.byte_role = ROLE_DROP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         case (phase_ff)
            PH_TYPE: begin
               type_ff  <= data_byte[7:4];
               flags_ff <= data_byte[3:0];
               rl_ff    <= '0;
               idx_ff   <= '0;
               pos_ff   <= '0;
               tl_ff    <= '0;
               id_ff    <= '0;
               fcb_ff   <= '0;
            end
            PH_LEN: begin
               rl_ff <= rl_len;
               if (data_byte[7] && !len_overflow) begin
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            PH_BODY: begin
               fcb_ff <= fcb_eff;
               tl_ff  <= tl_eff;
               id_ff  <= id_eff;
               if (!pos_last) begin
                  pos_ff <= pos_ff + LEN_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("parser left the halted phase without reset");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> pos_ff < rl_ff)
      else $error("content position ran past the remaining length");

   a_done_ends_packet: assert property (@(posedge clock) disable iff (reset)
      step && result.packet_done |=> phase_ff == PH_TYPE || phase_ff == PH_HALT)
      else $error("packet end did not return to header or halt");
`endif

endmodule

### rtl/core/mcpp_out_stage.sv
// ----------------------------------------------------------------------------
// MQTT parser result register
// Holds one tagged result until the receiver takes it.
// ----------------------------------------------------------------------------
module mcpp_out_stage import mcpp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  rsp_type   result,
   output logic      free,
   mcpp_rsp_if.source rsp_chan
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.byte_role    = data_ff.byte_role;
   assign rsp_chan.data_out     = data_ff.data_out;
   assign rsp_chan.packet_done  = data_ff.packet_done;
   assign rsp_chan.status       = data_ff.status;
   assign rsp_chan.packet_type  = data_ff.packet_type;
   assign rsp_chan.header_flags = data_ff.header_flags;
   assign rsp_chan.session_flag = data_ff.session_flag;
   assign rsp_chan.connack_code = data_ff.connack_code;
   assign rsp_chan.packet_ident = data_ff.packet_ident;
   assign rsp_chan.topic_length = data_ff.topic_length;
   assign rsp_chan.body_count   = data_ff.body_count;

endmodule

### rtl/core/mqtt_client_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// MQTT client packet parser
// Byte-serial parser for packets received from an MQTT 3.1.1 broker.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries the received stream one byte per request. For every
//   request byte, rsp_chan returns exactly one result that tags the byte's
//   role (type, length, fixed field, topic, payload, return code, discarded)
//   and passes the byte through. On a packet's last byte the result carries
//   packet_done with the status and the decoded fields.
//   A request accepted on req_chan is held in the input register, decoded
//   by the parse step and registered in the result register for rsp_chan.
//   Throughput is one byte per cycle while the receiver takes every result;
//   the per-byte state update in the parse step is the loop that sets it.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; req_chan.ready then drops until
//   the result is taken.
//   Reset (synchronous) empties both registers and returns the parser to
//   waiting for a type byte. A malformed or unsupported packet halts the
//   parser: later bytes come back as discarded until the next reset.
// ----------------------------------------------------------------------------
module mqtt_client_packet_parser_unit import mcpp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mcpp_req_if.sink   req_chan,
   mcpp_rsp_if.source rsp_chan
);

   logic       in_valid;
   logic [7:0] in_byte;
   logic       out_free;
   logic       advance;
   rsp_type    result;

   assign advance = in_valid && out_free;

   mcpp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .valid_ff (in_valid),
      .byte_ff  (in_byte)
   );

   mcpp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte),
      .result    (result)
   );

   mcpp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("parse step did not produce a pending result");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// MQTT client packet parser testbench
// Streams broker packets into the parser and compares every tagged result
// against a byte-level prediction of roles, status and decoded fields. Both
// channels stall at random. The run ends with one broken packet, since an
// error halts the parser until reset.
// ----------------------------------------------------------------------------
module tb_top import mcpp_pkg::*; ();

   // Types a client never receives, and the reserved ones.
   localparam logic [3:0] PKT_RESERVED_LO = 4'd0;
   localparam logic [3:0] PKT_CONNECT     = 4'd1;
   localparam logic [3:0] PKT_SUBSCRIBE   = 4'd8;
   localparam logic [3:0] PKT_UNSUBSCRIBE = 4'd10;
   localparam logic [3:0] PKT_PINGREQ     = 4'd12;
   localparam logic [3:0] PKT_DISCONNECT  = 4'd14;
   localparam logic [3:0] PKT_RESERVED_HI = 4'd15;

   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned DRAIN_LIMIT = 1000;

   typedef enum int unsigned {
      BRK_LONG_LENGTH,
      BRK_QOS3,
      BRK_QOS2,
      BRK_BAD_TYPE,
      BRK_BAD_FLAGS,
      BRK_BAD_LENGTH,
      BRK_CONNACK_BITS,
      BRK_TOPIC_OVERRUN,
      BRK_NO_IDENT,
      BRK_SHORT_PUBLISH
   } broken_kind_type;

   logic clock;
   logic reset;

   mcpp_req_if req_chan();
   mcpp_rsp_if rsp_chan();

   mqtt_client_packet_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Parser state as the predictor tracks it.
   phase_type        stage      = PH_TYPE;
   logic [3:0]       hdr_type   = '0;
   logic [3:0]       hdr_flags  = '0;
   logic [LEN_W-1:0] rem_len    = '0;
   logic [1:0]       len_count  = '0;
   logic [LEN_W-1:0] body_pos   = '0;
   logic [15:0]      topic_size = '0;
   logic [15:0]      ident_acc  = '0;
   logic [7:0]       lead_byte  = '0;

   rsp_type     pending_tags[$];
   rsp_type     want;
   logic [7:0]  pkt[$];
   bit          stalls_on = 1'b1;
   int unsigned mismatches = 0;
   int unsigned bytes_sent = 0;
   int unsigned idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------
   function automatic logic [2:0] content_role(input int unsigned p);
      case (hdr_type) inside
         PKT_CONNACK, PKT_PUBACK, PKT_PUBREC, PKT_PUBREL, PKT_PUBCOMP, PKT_UNSUBACK:
            return (p < 2) ? ROLE_FIXED : ROLE_DROP;
         PKT_SUBACK:
            return (p < 2) ? ROLE_FIXED : ROLE_CODE;
         PKT_PUBLISH: begin
            if (hdr_flags[2:1] == QOS_2 || hdr_flags[2:1] == QOS_3) return ROLE_DROP;
            if (p < 2) return ROLE_FIXED;
            if (p < 2 + topic_size) return ROLE_TOPIC;
            if (hdr_flags[2:1] == QOS_1 && p < 4 + topic_size) return ROLE_FIXED;
            return ROLE_PAYLOAD;
         end
         default: return ROLE_DROP;
      endcase
   endfunction

   // Checks a complete packet on its last byte and fills in the decoded fields.
   function automatic rsp_type judge_packet(input rsp_type r, input logic [7:0] last);
      logic [1:0]  st;
      logic [1:0]  qos;
      logic        sp;
      logic [7:0]  rc;
      logic [15:0] id;
      logic [15:0] tl;
      int unsigned rl;
      int unsigned need;
      int unsigned body;
      st = ST_OK;
      sp = 1'b0;
      rc = '0;
      id = '0;
      tl = '0;
      body = 0;
      rl = 32'(rem_len);
      qos = hdr_flags[2:1];
      need = 2 + 32'(topic_size);
      case (hdr_type) inside
         PKT_CONNACK: begin
            if (rl != 2 || hdr_flags != FLAGS_NONE || lead_byte[7:1] != 7'd0) begin
               st = ST_MALFORMED;
            end else begin
               sp = lead_byte[0];
               rc = last;
            end
         end
         PKT_PUBLISH: begin
            if (qos == QOS_3) begin
               st = ST_MALFORMED;
            end else if (qos == QOS_2) begin
               st = ST_QOS2;
            end else if (rl < 2 || need > rl) begin
               st = ST_MALFORMED;
            end else begin
               if (qos == QOS_1) begin
                  if (need + 2 > rl) begin
                     st = ST_MALFORMED;
                  end else begin
                     id = ident_acc;
                     need = need + 2;
                  end
               end
               if (st == ST_OK) begin
                  tl = topic_size;
                  body = rl - need;
               end
            end
         end
         PKT_PUBACK, PKT_PUBREC, PKT_PUBCOMP, PKT_UNSUBACK: begin
            if (rl != 2 || hdr_flags != FLAGS_NONE) st = ST_MALFORMED;
            else id = ident_acc;
         end
         PKT_PUBREL: begin
            if (rl != 2 || hdr_flags != FLAGS_PUBREL) st = ST_MALFORMED;
            else id = ident_acc;
         end
         PKT_SUBACK: begin
            if (rl < 3 || hdr_flags != FLAGS_NONE) begin
               st = ST_MALFORMED;
            end else begin
               id = ident_acc;
               body = rl - 2;
            end
         end
         PKT_PINGRESP: begin
            if (rl != 0 || hdr_flags != FLAGS_NONE) st = ST_MALFORMED;
         end
         default: st = ST_MALFORMED;
      endcase
      r.packet_done = 1'b1;
      r.status = st;
      if (st == ST_OK) begin
         r.session_flag = sp;
         r.connack_code = rc;
         r.packet_ident = id;
         r.topic_length = tl;
         r.body_count = LEN_W'(body);
         stage = PH_TYPE;
      end else begin
         stage = PH_HALT;
      end
      return r;
   endfunction

   function automatic rsp_type tag_byte(input logic [7:0] b);
      rsp_type     r;
      int unsigned p;
      r = '0;
      r.data_out = b;
      case (stage)
         PH_TYPE: begin
            rem_len = '0;
            len_count = '0;
            body_pos = '0;
            topic_size = '0;
            ident_acc = '0;
            lead_byte = '0;
            hdr_type = b[7:4];
            hdr_flags = b[3:0];
            r.byte_role = ROLE_TYPE;
            r.packet_type = hdr_type;
            r.header_flags = hdr_flags;
            stage = PH_LEN;
         end
         PH_LEN: begin
            r.byte_role = ROLE_LEN;
            r.packet_type = hdr_type;
            r.header_flags = hdr_flags;
            rem_len = rem_len + (LEN_W'(b[6:0]) << (7 * len_count));
            if (b[7]) begin
               // A continuation bit on the fourth length byte cannot be decoded.
               if (len_count == 2'd3) begin
                  r.packet_done = 1'b1;
                  r.status = ST_MALFORMED;
                  stage = PH_HALT;
               end else begin
                  len_count++;
               end
            end else if (rem_len == '0) begin
               r = judge_packet(r, b);
            end else begin
               body_pos = '0;
               stage = PH_BODY;
            end
         end
         PH_BODY: begin
            p = 32'(body_pos);
            r.byte_role = content_role(p);
            r.packet_type = hdr_type;
            r.header_flags = hdr_flags;
            if (p == 0) lead_byte = b;
            if (hdr_type == PKT_PUBLISH) begin
               if (p == 1) topic_size = {lead_byte, b};
               if (hdr_flags[2:1] == QOS_1 && p >= 2 &&
                   (p == 2 + topic_size || p == 3 + topic_size))
                  ident_acc = {ident_acc[7:0], b};
            end else if (p < 2) begin
               ident_acc = {ident_acc[7:0], b};
            end
            if (p + 1 >= rem_len) r = judge_packet(r, b);
            else body_pos = LEN_W'(p + 1);
         end
         default: r.byte_role = ROLE_DROP;
      endcase
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, exp_val);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            pending_tags.push_back(tag_byte(req_chan.data_byte));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_tags.size() == 0) begin
               report_mismatch("result with no request pending",
                               32'(rsp_chan.data_out), 0);
            end else begin
               want = pending_tags.pop_front();
               if (rsp_chan.byte_role !== want.byte_role)
                  report_mismatch("byte_role", 32'(rsp_chan.byte_role),
                                  32'(want.byte_role));
               if (rsp_chan.data_out !== want.data_out)
                  report_mismatch("data_out", 32'(rsp_chan.data_out),
                                  32'(want.data_out));
               if (rsp_chan.packet_done !== want.packet_done)
                  report_mismatch("packet_done", 32'(rsp_chan.packet_done),
                                  32'(want.packet_done));
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
               if (rsp_chan.packet_type !== want.packet_type)
                  report_mismatch("packet_type", 32'(rsp_chan.packet_type),
                                  32'(want.packet_type));
               if (rsp_chan.header_flags !== want.header_flags)
                  report_mismatch("header_flags", 32'(rsp_chan.header_flags),
                                  32'(want.header_flags));
               if (rsp_chan.session_flag !== want.session_flag)
                  report_mismatch("session_flag", 32'(rsp_chan.session_flag),
                                  32'(want.session_flag));
               if (rsp_chan.connack_code !== want.connack_code)
                  report_mismatch("connack_code", 32'(rsp_chan.connack_code),
                                  32'(want.connack_code));
               if (rsp_chan.packet_ident !== want.packet_ident)
                  report_mismatch("packet_ident", 32'(rsp_chan.packet_ident),
                                  32'(want.packet_ident));
               if (rsp_chan.topic_length !== want.topic_length)
                  report_mismatch("topic_length", 32'(rsp_chan.topic_length),
                                  32'(want.topic_length));
               if (rsp_chan.body_count !== want.body_count)
                  report_mismatch("body_count", 32'(rsp_chan.body_count),
                                  32'(want.body_count));
            end
         end
      end
   end

   // Ends a run in which neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !stalls_on || ($urandom_range(99) >= 7);
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after the request
   // is taken, with valid still high so back-to-back bytes need no gap.
   task automatic send_byte(input logic [7:0] b);
      while (stalls_on && $urandom_range(99) < 7) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic flush_packet();
      foreach (pkt[i]) send_byte(pkt[i]);
      pkt.delete();
   endtask

   task automatic put_random(input int unsigned n);
      repeat (n) pkt.push_back(8'($urandom()));
   endtask

   // Remaining length over k bytes; k of zero picks the shortest form most
   // of the time and a padded form with zero groups otherwise.
   task automatic put_length(input int unsigned n, input int unsigned k);
      int unsigned groups;
      groups = 1;
      while (groups < 4 && (n >> (7 * groups)) != 0) groups++;
      if (k == 0) k = ($urandom_range(99) < 20) ? $urandom_range(4, groups) : groups;
      else if (k < groups) k = groups;
      for (int unsigned i = 0; i < k; i++)
         pkt.push_back({1'(i + 1 < k), 7'(n >> (7 * i))});
   endtask

   task automatic put_frame(input logic [7:0] hdr, input int unsigned rl);
      pkt.push_back(hdr);
      put_length(rl, 0);
      put_random(rl);
   endtask

   function automatic logic [3:0] fixed_flags(input logic [3:0] t);
      return (t == PKT_PUBREL) ? FLAGS_PUBREL : FLAGS_NONE;
   endfunction

   function automatic logic [3:0] pick_publish_flags();
      return {1'($urandom()), 1'b0, 1'($urandom()), 1'($urandom())};
   endfunction

   function automatic logic [3:0] pick_control_type();
      case ($urandom_range(7))
         0: return PKT_CONNACK;
         1: return PKT_PUBACK;
         2: return PKT_PUBREC;
         3: return PKT_PUBREL;
         4: return PKT_PUBCOMP;
         5: return PKT_SUBACK;
         6: return PKT_UNSUBACK;
         default: return PKT_PINGRESP;
      endcase
   endfunction

   task automatic build_connack(input logic [7:0] ack_bits, input logic [7:0] rc,
                                input int unsigned k);
      pkt.push_back({PKT_CONNACK, FLAGS_NONE});
      put_length(2, k);
      pkt.push_back(ack_bits);
      pkt.push_back(rc);
   endtask

   task automatic build_publish(input logic [3:0] flags, input logic [15:0] id,
                                input int unsigned topic_n, input int unsigned payload_n,
                                input int unsigned k);
      pkt.push_back({PKT_PUBLISH, flags});
      put_length(2 + topic_n + payload_n + ((flags[2:1] == QOS_1) ? 2 : 0), k);
      pkt.push_back(8'(topic_n >> 8));
      pkt.push_back(8'(topic_n));
      put_random(topic_n);
      if (flags[2:1] == QOS_1) begin
         pkt.push_back(id[15:8]);
         pkt.push_back(id[7:0]);
      end
      put_random(payload_n);
   endtask

   task automatic build_ack(input logic [3:0] t, input logic [15:0] id, input int unsigned k);
      pkt.push_back({t, fixed_flags(t)});
      put_length(2, k);
      pkt.push_back(id[15:8]);
      pkt.push_back(id[7:0]);
   endtask

   task automatic build_suback(input logic [15:0] id, input int unsigned codes,
                               input int unsigned k);
      pkt.push_back({PKT_SUBACK, FLAGS_NONE});
      put_length(2 + codes, k);
      pkt.push_back(id[15:8]);
      pkt.push_back(id[7:0]);
      put_random(codes);
   endtask

   task automatic build_pingresp(input int unsigned k);
      pkt.push_back({PKT_PINGRESP, FLAGS_NONE});
      put_length(0, k);
   endtask

   task automatic build_random_packet();
      int unsigned topic_n;
      int unsigned payload_n;
      logic [3:0]  t;
      if ($urandom_range(99) < 45) begin
         // Mostly short topics and payloads; a few long enough to need a
         // second length byte or a topic length above one byte.
         topic_n = ($urandom_range(99) < 2) ? $urandom_range(300, 256) : $urandom_range(12);
         payload_n = ($urandom_range(99) < 3) ? $urandom_range(260, 128) : $urandom_range(16);
         build_publish(pick_publish_flags(), 16'($urandom()), topic_n, payload_n, 0);
      end else begin
         t = pick_control_type();
         case (t)
            PKT_CONNACK:  build_connack({7'd0, 1'($urandom())}, 8'($urandom()), 0);
            PKT_SUBACK:   build_suback(16'($urandom()), $urandom_range(8, 1), 0);
            PKT_PINGRESP: build_pingresp(0);
            default:      build_ack(t, 16'($urandom()), 0);
         endcase
      end
   endtask

   task automatic build_broken_packet();
      broken_kind_type kind;
      logic [3:0]      t;
      logic [3:0]      flags;
      int unsigned     rl;
      int unsigned     tlen;
      kind = broken_kind_type'($urandom_range(BRK_SHORT_PUBLISH));
      case (kind) inside
         BRK_LONG_LENGTH: begin
            pkt.push_back(8'($urandom()));
            repeat (4) pkt.push_back({1'b1, 7'($urandom())});
         end
         BRK_QOS3:
            build_publish({1'($urandom()), QOS_3, 1'($urandom())}, 16'($urandom()),
                          $urandom_range(4), $urandom_range(4), 0);
         BRK_QOS2:
            build_publish({1'($urandom()), QOS_2, 1'($urandom())}, 16'($urandom()),
                          $urandom_range(4), $urandom_range(4), 0);
         BRK_BAD_TYPE: begin
            case ($urandom_range(6))
               0: t = PKT_RESERVED_LO;
               1: t = PKT_CONNECT;
               2: t = PKT_SUBSCRIBE;
               3: t = PKT_UNSUBSCRIBE;
               4: t = PKT_PINGREQ;
               5: t = PKT_DISCONNECT;
               default: t = PKT_RESERVED_HI;
            endcase
            put_frame({t, 4'($urandom())}, $urandom_range(5));
         end
         BRK_BAD_FLAGS: begin
            t = pick_control_type();
            flags = 4'($urandom_range(15, 1));
            if (t == PKT_PUBREL && flags == FLAGS_PUBREL) flags = FLAGS_NONE;
            if (t == PKT_PINGRESP) rl = 0;
            else if (t == PKT_SUBACK) rl = $urandom_range(6, 3);
            else rl = 2;
            put_frame({t, flags}, rl);
         end
         BRK_BAD_LENGTH: begin
            t = pick_control_type();
            if (t == PKT_PINGRESP) begin
               rl = $urandom_range(4, 1);
            end else if (t == PKT_SUBACK) begin
               rl = $urandom_range(2);
            end else begin
               rl = $urandom_range(4);
               if (rl >= 2) rl++;
            end
            put_frame({t, fixed_flags(t)}, rl);
         end
         BRK_CONNACK_BITS:
            build_connack({7'($urandom_range(127, 1)), 1'($urandom())}, 8'($urandom()), 0);
         BRK_TOPIC_OVERRUN, BRK_NO_IDENT: begin
            if (kind == BRK_TOPIC_OVERRUN) begin
               // The topic runs past the end of the packet.
               rl = $urandom_range(8, 2);
               tlen = $urandom_range(65535, rl - 1);
               flags = pick_publish_flags();
            end else begin
               // QoS 1 with no room left for the identifier.
               tlen = $urandom_range(5);
               rl = 2 + tlen + $urandom_range(1);
               flags = {1'($urandom()), QOS_1, 1'($urandom())};
            end
            pkt.push_back({PKT_PUBLISH, flags});
            put_length(rl, 0);
            pkt.push_back(8'(tlen >> 8));
            pkt.push_back(8'(tlen));
            put_random(rl - 2);
         end
         default: put_frame({PKT_PUBLISH, pick_publish_flags()}, $urandom_range(1));
      endcase
   endtask

   task automatic stream_packets(input int unsigned count);
      int unsigned stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         build_random_packet();
         flush_packet();
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_each_packet_type();
      build_pingresp(1);
      build_pingresp(2);
      build_connack(8'h01, 8'hFF, 1);
      build_publish({1'b1, 1'b0, 1'b1, 1'b1}, 16'hFFFF, 0, 0, 1);
      build_publish(FLAGS_NONE, 16'h0000, 0, 1, 4);
      build_ack(PKT_PUBACK, 16'h0000, 1);
      build_ack(PKT_PUBREC, 16'hFFFF, 1);
      build_ack(PKT_PUBREL, 16'h8001, 1);
      build_ack(PKT_PUBCOMP, 16'h7FFE, 1);
      build_ack(PKT_UNSUBACK, 16'($urandom()), 1);
      build_suback(16'($urandom()), 1, 1);
      flush_packet();
   endtask

   task automatic test_random_traffic(input int unsigned count);
      stream_packets(count);
   endtask

   task automatic test_no_stalls(input int unsigned count);
      stalls_on = 1'b0;
      stream_packets(count);
      stalls_on = 1'b1;
   endtask

   // Any error halts the parser until reset, so this comes last: one broken
   // packet, then a run of bytes that must all come back discarded.
   task automatic test_error_halt();
      build_broken_packet();
      put_random($urandom_range(30, 10));
      flush_packet();
   endtask

   initial begin
      int unsigned waited;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      rsp_chan.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_each_packet_type();
      test_random_traffic(950);
      test_no_stalls(250);
      test_random_traffic(350);
      test_error_halt();
      req_chan.valid <= 1'b0;

      waited = 0;
      while (pending_tags.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_tags.size() != 0)
         report_mismatch("results never returned", pending_tags.size(), 0);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### mqtt_client_packet_parser_unit.f
rtl/core/mcpp_pkg.sv
rtl/core/mcpp_if.sv
rtl/core/mcpp_in_stage.sv
rtl/core/mcpp_parse.sv
rtl/core/mcpp_out_stage.sv
rtl/core/mqtt_client_packet_parser_unit.sv
tb/tb_top.sv
